[rtl/hcbp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_pkg
// Types, opcodes and helpers shared by the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int OPC_W  = 2;
  localparam int SYM_W  = 8;
  localparam int WORD_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;
  localparam int PEND_W = 7;
  localparam int CNT_W  = 3;
  localparam int ACC_W  = PEND_W + WORD_W;
  localparam int TOT_W  = 6;

  localparam logic [OPC_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OPC_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OPC_W-1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [SYM_W-1:0]  symbol;
    logic [WORD_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
  } in_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic [WORD_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } tbl_entry_t;

  typedef struct packed {
    logic encode;
    logic flush;
    logic emit;
  } pkr_ctrl_t;

  typedef struct packed {
    logic has_byte;
    logic has_pending;
    logic out_free;
  } pkr_stat_t;

  function automatic logic [WORD_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [WORD_W-1:0] m;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = (LEN_W'(i) < len);
    end
    return m;
  endfunction

  function automatic logic [PEND_W-1:0] pend_mask(input logic [CNT_W-1:0] cnt);
    logic [PEND_W-1:0] m;
    for (int i = 0; i < PEND_W; i++) begin
      m[i] = (CNT_W'(i) < cnt);
    end
    return m;
  endfunction

endpackage

[rtl/huffman_code_bit_packer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_top
// Table-driven Huffman encoder: code table load, encode, flush to bytes.
// ----------------------------------------------------------------------------
// Load: written to the code table when the beat is taken. Encode: accept,
// table read, one emit step per output byte and an end-of-run step; the table
// read port and the single output byte register set this order. Flush: accept,
// one emit step and an end-of-run step, only the accept with nothing pending.
// Output stalls hold each emit step until the byte register frees up.
// Reset clears pending bits and control; the code table holds no reset value.
module huffman_code_bit_packer_top #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hcbp_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hcbp_pkg::out_beat_t out_data
);

  localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
  localparam int CAP_LEN = (MAX_CODE_LEN < hcbp_pkg::WORD_W) ? MAX_CODE_LEN
                                                             : hcbp_pkg::WORD_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic                       in_acc;
  logic                       sym_ok;
  logic [hcbp_pkg::LEN_W-1:0] cap_len;
  logic                       wr_en;
  logic                       rd_en;
  hcbp_pkg::tbl_entry_t       wr_data;
  hcbp_pkg::tbl_entry_t       rd_data;
  hcbp_pkg::pkr_ctrl_t        ctrl;
  hcbp_pkg::pkr_stat_t        stat;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign sym_ok   = ({1'b0, in_data.symbol} < 9'(SYMBOL_COUNT));
  assign cap_len  = (in_data.code_length > hcbp_pkg::LEN_W'(CAP_LEN))
                    ? hcbp_pkg::LEN_W'(CAP_LEN) : in_data.code_length;

  assign wr_data.code = in_data.code_word & hcbp_pkg::len_mask(cap_len);
  assign wr_data.len  = cap_len;
  assign wr_en = in_acc && sym_ok && (in_data.opcode == hcbp_pkg::OP_LOAD);
  assign rd_en = in_acc && sym_ok && (in_data.opcode == hcbp_pkg::OP_ENCODE);

  always_comb begin
    state_nxt   = state_r;
    ctrl.encode = 1'b0;
    ctrl.flush  = 1'b0;
    ctrl.emit   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (rd_en) begin
          state_nxt = ST_LOOKUP;
        end else if (in_acc && (in_data.opcode == hcbp_pkg::OP_FLUSH)
                     && stat.has_pending) begin
          ctrl.flush = 1'b1;
          state_nxt  = ST_EMIT;
        end
      end
      ST_LOOKUP: begin
        ctrl.encode = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.has_byte) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          ctrl.emit = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  hcbp_code_mem #(
    .DEPTH  (SYMBOL_COUNT),
    .ADDR_W (ADDR_W)
  ) u_code_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_data.symbol[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (in_data.symbol[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  hcbp_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .entry     (rd_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

endmodule

[rtl/hcbp_code_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_code_mem
// Code table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hcbp_code_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  hcbp_pkg::tbl_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr,
  output hcbp_pkg::tbl_entry_t rd_data
);

  hcbp_pkg::tbl_entry_t mem [DEPTH];
  hcbp_pkg::tbl_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/hcbp_packer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_packer
// Bit accumulator and output byte register, MSB first.
// ----------------------------------------------------------------------------
module hcbp_packer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hcbp_pkg::pkr_ctrl_t   ctrl,
  input  hcbp_pkg::tbl_entry_t  entry,
  input  logic                  out_stall,
  output logic                  out_valid,
  output hcbp_pkg::out_beat_t   out_data,
  output hcbp_pkg::pkr_stat_t   stat
);

  logic [hcbp_pkg::ACC_W-1:0]  acc_r,       acc_nxt;
  logic [hcbp_pkg::TOT_W-1:0]  total_r,     total_nxt;
  logic                        out_valid_r, out_valid_nxt;
  hcbp_pkg::out_beat_t         out_data_r,  out_data_nxt;

  logic [hcbp_pkg::PEND_W-1:0] pend;
  logic [hcbp_pkg::TOT_W-1:0]  shamt;
  logic [hcbp_pkg::ACC_W-1:0]  shifted;

  assign pend    = acc_r[hcbp_pkg::PEND_W-1:0]
                   & hcbp_pkg::pend_mask(total_r[hcbp_pkg::CNT_W-1:0]);
  assign shamt   = total_r - hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W);
  assign shifted = acc_r >> shamt;

  always_comb begin
    acc_nxt       = acc_r;
    total_nxt     = total_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (ctrl.encode) begin
      acc_nxt   = (hcbp_pkg::ACC_W'(pend) << entry.len)
                  | hcbp_pkg::ACC_W'(entry.code);
      total_nxt = total_r + entry.len;
    end else if (ctrl.flush) begin
      acc_nxt   = hcbp_pkg::ACC_W'(pend)
                  << (4'd8 - {1'b0, total_r[hcbp_pkg::CNT_W-1:0]});
      total_nxt = hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W);
    end else if (ctrl.emit) begin
      total_nxt                = shamt;
      out_data_nxt.packed_byte = shifted[hcbp_pkg::BYTE_W-1:0];
      out_data_nxt.last_of_run = (shamt < hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W));
      out_valid_nxt            = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign stat.has_byte    = (total_r >= hcbp_pkg::TOT_W'(hcbp_pkg::BYTE_W));
  assign stat.has_pending = (total_r != '0);
  assign stat.out_free    = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;

endmodule

[rtl/hcbp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks for the Huffman code bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module hcbp_checker #(
  parameter int SYMBOL_COUNT = 256
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input hcbp_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input hcbp_pkg::out_beat_t out_data
);

  logic in_beat;
  logic out_beat;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  a_load_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_data.opcode == hcbp_pkg::OP_LOAD) |=> !in_stall)
    else $error("load beat left the block busy");

  a_encode_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat && (in_data.opcode == hcbp_pkg::OP_ENCODE)
    && ({1'b0, in_data.symbol} < 9'(SYMBOL_COUNT)) |=> in_stall)
    else $error("encode beat did not start a table lookup");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && !out_data.last_of_run |=> in_stall)
    else $error("input taken before the byte run ended");

endmodule

bind huffman_code_bit_packer_top hcbp_checker #(
  .SYMBOL_COUNT (SYMBOL_COUNT)
) u_hcbp_checker (.*);

[tb/tb_huffman_code_bit_packer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_code_bit_packer_top
// Self-checking bench for the table-driven Huffman bit packer. A directed
// table covers table loads, length capping, stray code bits, flush, the
// unused opcode and four-byte runs; random load/encode/flush and unused-opcode
// traffic follows. Every output beat is checked against the table's bytes or an
// in-bench bit packer, with random idling on both channels but in the last pass.
// ----------------------------------------------------------------------------
module tb_huffman_code_bit_packer_top;

  localparam int                         SYMBOL_COUNT   = 256;
  localparam int                         MAX_CODE_LEN   = 32;
  localparam logic [hcbp_pkg::OPC_W-1:0] OP_UNUSED      = 2'd3;
  localparam int                         NUM_DIR        = 24;
  localparam int                         ITEMS_PER_PASS = 136;
  localparam int                         DRAIN_CYCLES   = 20;
  localparam int                         WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    hcbp_pkg::in_beat_t beat;
    logic               typed;
    logic [2:0]         n_bytes;
    logic [31:0]        bytes;
  } dir_row_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  hcbp_pkg::in_beat_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  hcbp_pkg::out_beat_t out_data;

  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned err_cnt       = 0;
  int unsigned idle_cycles   = 0;

  // packer state mirrored by the bench
  logic [hcbp_pkg::WORD_W-1:0] code_mem [SYMBOL_COUNT];
  logic [hcbp_pkg::LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
  logic [hcbp_pkg::PEND_W-1:0] pend_bits = '0;
  logic [hcbp_pkg::CNT_W-1:0]  pend_cnt  = '0;

  hcbp_pkg::out_beat_t expected_bytes_q[$];
  logic [7:0]          loaded_syms[$];
  bit                  sym_loaded [SYMBOL_COUNT];
  dir_row_t            dir_rows [NUM_DIR];

  huffman_code_bit_packer_top #(
    .SYMBOL_COUNT(SYMBOL_COUNT),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic dir_row_t mk_row(logic [hcbp_pkg::OPC_W-1:0] op, logic [7:0] sym,
                                      logic [31:0] word, logic [5:0] clen,
                                      logic typed, logic [2:0] n,
                                      logic [31:0] bytes);
    dir_row_t r;
    r.beat.opcode      = op;
    r.beat.symbol      = sym;
    r.beat.code_word   = word;
    r.beat.code_length = clen;
    r.typed            = typed;
    r.n_bytes          = n;
    r.bytes            = bytes;
    return r;
  endfunction

  function automatic void predict_packed_bytes(input hcbp_pkg::in_beat_t b,
                                               ref hcbp_pkg::out_beat_t q[$]);
    logic [hcbp_pkg::ACC_W-1:0] acc;
    logic [63:0]                mask;
    int unsigned                len;
    int unsigned                total;
    hcbp_pkg::out_beat_t        ob;
    unique case (b.opcode)
      hcbp_pkg::OP_LOAD: begin
        if (int'(b.symbol) < SYMBOL_COUNT) begin
          len = b.code_length;
          if (len > MAX_CODE_LEN) len = MAX_CODE_LEN;
          if (len > hcbp_pkg::WORD_W) len = hcbp_pkg::WORD_W;
          mask = (len == 0) ? 64'd0 : ((64'd1 << len) - 64'd1);
          code_mem[b.symbol] = b.code_word & mask[hcbp_pkg::WORD_W-1:0];
          len_mem[b.symbol]  = hcbp_pkg::LEN_W'(len);
        end
      end
      hcbp_pkg::OP_ENCODE: begin
        if (int'(b.symbol) < SYMBOL_COUNT) begin
          len   = len_mem[b.symbol];
          acc   = (hcbp_pkg::ACC_W'(pend_bits) << len)
                  | hcbp_pkg::ACC_W'(code_mem[b.symbol]);
          total = pend_cnt + len;
          while (total >= hcbp_pkg::BYTE_W) begin
            total          = total - hcbp_pkg::BYTE_W;
            ob.packed_byte = acc[total +: hcbp_pkg::BYTE_W];
            ob.last_of_run = (total < hcbp_pkg::BYTE_W);
            q.push_back(ob);
          end
          pend_bits = hcbp_pkg::PEND_W'(acc & ((hcbp_pkg::ACC_W'(1) << total)
                                               - hcbp_pkg::ACC_W'(1)));
          pend_cnt  = hcbp_pkg::CNT_W'(total);
        end
      end
      hcbp_pkg::OP_FLUSH: begin
        if (pend_cnt != 0) begin
          ob.packed_byte = hcbp_pkg::BYTE_W'(16'(pend_bits)
                                             << (hcbp_pkg::BYTE_W - pend_cnt));
          ob.last_of_run = 1'b1;
          q.push_back(ob);
          pend_bits = '0;
          pend_cnt  = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // hold the beat until accepted, then record what it should produce
  task automatic send_item(input dir_row_t r);
    hcbp_pkg::out_beat_t produced[$];
    hcbp_pkg::out_beat_t ob;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r.beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_packed_bytes(r.beat, produced);
    if (r.typed) begin
      for (int k = 0; k < r.n_bytes; k++) begin
        ob.packed_byte = r.bytes[31 - 8*k -: 8];
        ob.last_of_run = (k == r.n_bytes - 1);
        expected_bytes_q.push_back(ob);
      end
    end else begin
      foreach (produced[k]) expected_bytes_q.push_back(produced[k]);
    end
  endtask

  function automatic hcbp_pkg::in_beat_t next_random_beat();
    hcbp_pkg::in_beat_t b;
    int unsigned        pick;
    int unsigned        span;
    b.opcode    = hcbp_pkg::OP_LOAD;
    b.symbol    = 8'($urandom);
    b.code_word = $urandom;
    span        = $urandom_range(9);
    if (span < 7) b.code_length = 6'($urandom_range(12, 1));
    else if (span < 9) b.code_length = 6'($urandom_range(32, 13));
    else b.code_length = 6'($urandom_range(63, 0));
    pick = $urandom_range(99);
    if (loaded_syms.size() == 0 || pick < 15) begin
      if (!sym_loaded[b.symbol]) begin
        sym_loaded[b.symbol] = 1'b1;
        loaded_syms.push_back(b.symbol);
      end
    end else begin
      b.symbol = loaded_syms[$urandom_range(loaded_syms.size() - 1)];
      if (pick < 85) b.opcode = hcbp_pkg::OP_ENCODE;
      else if (pick < 95) b.opcode = hcbp_pkg::OP_FLUSH;
      else b.opcode = OP_UNUSED;
    end
    return b;
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < snk_stall_pct);
  end

  always @(posedge clk) begin
    hcbp_pkg::out_beat_t exp_b;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes_q.size() == 0) begin
        $error("packed_byte: expected none, got %h (last_of_run %b)",
               out_data.packed_byte, out_data.last_of_run);
        err_cnt++;
      end else begin
        exp_b = expected_bytes_q.pop_front();
        if (out_data.packed_byte !== exp_b.packed_byte) begin
          $error("packed_byte: expected %h, got %h", exp_b.packed_byte,
                 out_data.packed_byte);
          err_cnt++;
        end
        if (out_data.last_of_run !== exp_b.last_of_run) begin
          $error("last_of_run: expected %b, got %b", exp_b.last_of_run,
                 out_data.last_of_run);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb_huffman_code_bit_packer_top NOT OK");
    $finish;
  end

  initial begin
    int unsigned        sent;
    hcbp_pkg::in_beat_t b;
    dir_rows = '{
      mk_row(hcbp_pkg::OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_LOAD,   8'h41, 32'hFFFF_FFA5, 6'd8,  1'b1, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_ENCODE, 8'h41, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'hA500_0000),
      mk_row(hcbp_pkg::OP_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b1, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b1, 3'd4, 32'hFFFF_FFFF),
      mk_row(hcbp_pkg::OP_LOAD,   8'h00, 32'h89AB_CDEF, 6'd63, 1'b1, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd4, 32'h89AB_CDEF),
      mk_row(hcbp_pkg::OP_LOAD,   8'h01, 32'hFFFF_FFFF, 6'd1,  1'b1, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_FLUSH,  8'h01, 32'h0000_0000, 6'd0,  1'b1, 3'd1, 32'h8000_0000),
      mk_row(hcbp_pkg::OP_FLUSH,  8'h01, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_LOAD,   8'h02, 32'hDEAD_BEEF, 6'd0,  1'b1, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b1, 3'd0, 32'h0),
      mk_row(OP_UNUSED,           8'h41, 32'hFFFF_FFFF, 6'd63, 1'b1, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_LOAD,   8'h80, 32'h0000_002A, 6'd7,  1'b1, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_LOAD,   8'h7F, 32'h0000_0003, 6'd2,  1'b1, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_LOAD,   8'h7F, 32'hF001_2345, 6'd20, 1'b1, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_ENCODE, 8'h7F, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0),
      mk_row(hcbp_pkg::OP_FLUSH,  8'h7F, 32'h0000_0000, 6'd0,  1'b0, 3'd0, 32'h0)
    };
    foreach (dir_rows[i]) begin
      if (dir_rows[i].beat.opcode == hcbp_pkg::OP_LOAD
          && !sym_loaded[dir_rows[i].beat.symbol]) begin
        sym_loaded[dir_rows[i].beat.symbol] = 1'b1;
        loaded_syms.push_back(dir_rows[i].beat.symbol);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct  = 11;
    snk_stall_pct = 63;
    foreach (dir_rows[i]) send_item(dir_rows[i]);

    for (int pass = 0; pass < 3; pass++) begin
      src_idle_pct  = (pass == 0) ? 11 : (pass == 1) ? 63 : 0;
      snk_stall_pct = (pass == 0) ? 63 : (pass == 1) ? 11 : 0;
      sent = 0;
      while (sent < ITEMS_PER_PASS) begin
        b = next_random_beat();
        send_item(mk_row(b.opcode, b.symbol, b.code_word, b.code_length,
                         1'b0, 3'd0, 32'h0));
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (expected_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0)
      $display("tb_huffman_code_bit_packer_top OK");
    else
      $display("tb_huffman_code_bit_packer_top NOT OK");
    $finish;
  end

endmodule
